// File: src/dfca_pkg.sv
// Shared types, constants and helper functions for the debug frame command agent.
`timescale 1ns / 1ps
package dfca_pkg;

  localparam int FORCE_SLOT_COUNT = 8;
  localparam int SLOT_IDX_W = (FORCE_SLOT_COUNT > 1) ? $clog2(FORCE_SLOT_COUNT) : 1;
  localparam int CFG_IDX_W = 8;

  localparam logic [7:0] CMD_OPEN    = 8'hA0;
  localparam logic [7:0] CMD_CLOSE   = 8'hA1;
  localparam logic [7:0] CMD_REBOOT  = 8'hA2;
  localparam logic [7:0] CMD_READ    = 8'hA5;
  localparam logic [7:0] CMD_WRITE8  = 8'hA6;
  localparam logic [7:0] CMD_WRITE16 = 8'hA7;
  localparam logic [7:0] CMD_FORCE8  = 8'hA8;
  localparam logic [7:0] CMD_FORCE16 = 8'hA9;
  localparam logic [7:0] CMD_RELEASE = 8'hAA;
  localparam logic [7:0] CMD_CTRL    = 8'hAC;
  localparam logic [7:0] CMD_TRACE   = 8'hB0;

  localparam logic [7:0] ACK_READ   = 8'h5A;
  localparam logic [7:0] ACK_WRITE  = 8'h6A;
  localparam logic [7:0] ACK_CTRL   = 8'hCA;
  localparam logic [7:0] ACK_TRACE  = 8'hB1;
  localparam logic [7:0] ACK_REBOOT = 8'hA3;

  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_T = 8'h54;

  localparam logic [7:0] STS_OK      = 8'd0;
  localparam logic [7:0] STS_RANGE   = 8'd1;
  localparam logic [7:0] STS_BADLEN  = 8'd2;
  localparam logic [7:0] STS_FULL    = 8'd3;
  localparam logic [7:0] STS_OFFLINE = 8'd4;

  localparam logic [7:0] MODE_RUN   = 8'd0;
  localparam logic [7:0] MODE_PAUSE = 8'd1;
  localparam logic [7:0] MODE_STEP  = 8'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_W0_LO = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_W0_HI = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_W1_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_W1_HI = CFG_IDX_W'(3);

  typedef enum logic [1:0] {IN_FRAME, IN_GATE, IN_TRACE, IN_NONE} in_kind_t;
  typedef enum logic [1:0] {RES_ACK, RES_WRITE, RES_GATE, RES_RESET} res_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SLOT, ST_HANDLE, ST_WR, ST_ACK, ST_RST, ST_FIN
  } fsm_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [63:0] ack;
    logic [31:0] addr;
    logic [1:0]  len;
    logic [15:0] val;
    logic        gate;
    logic        last;
  } res_t;

  typedef struct packed {
    logic                  cap;
    logic                  gen_slot;
    logic                  handle;
    logic                  gen_w;
    logic                  gen_ack;
    logic                  gen_rst;
    logic                  flush;
    logic [SLOT_IDX_W-1:0] slot_idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic slot_emit;
    logic gen_ok;
    logic pend_valid;
    logic out_free;
    logic need_w;
    logic need_ack;
    logic need_rst;
  } dp_sts_t;

  function automatic logic [7:0] sum7(input logic [63:0] f);
    logic [7:0] s;
    s = 8'd0;
    for (int i = 0; i < 7; i++) s = s + f[8*i +: 8];
    return s;
  endfunction

  function automatic logic [63:0] pack_ack(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [7:0] b4, input logic [7:0] b5);
    logic [7:0] c;
    c = b0 + b1 + b2 + b3 + b4 + b5;
    return {c, 8'h00, b5, b4, b3, b2, b1, b0};
  endfunction

  function automatic logic in_ram(input logic [31:0] addr, input logic [1:0] len,
                                  input logic [31:0] w0l, input logic [31:0] w0h,
                                  input logic [31:0] w1l, input logic [31:0] w1h);
    logic [32:0] e;
    e = {1'b0, addr} + {31'b0, len} - 33'd1;
    if (e[32]) return 1'b0;
    return (addr >= w0l && e[31:0] <= w0h) || (addr >= w1l && e[31:0] <= w1h);
  endfunction

endpackage

// File: src/dfca_ifs.sv
// Channel interfaces for input items, result items and configuration writes.
`timescale 1ns / 1ps
interface dfca_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] frame_bytes;
  logic [15:0] trace_id;
  logic [15:0] mem_read_data;
  modport source (output valid, kind, frame_bytes, trace_id, mem_read_data, input ready);
  modport sink (input valid, kind, frame_bytes, trace_id, mem_read_data, output ready);
endinterface

interface dfca_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [63:0] ack_frame;
  logic [31:0] write_addr;
  logic [1:0]  write_len;
  logic [15:0] write_value;
  logic        gate_open;
  logic        last;
  modport source (output valid, out_kind, ack_frame, write_addr, write_len, write_value,
                  gate_open, last, input ready);
  modport sink (input valid, out_kind, ack_frame, write_addr, write_len, write_value,
                gate_open, last, output ready);
endinterface

interface dfca_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/debug_frame_command_agent.sv
// Top level of the debug frame command agent.
//   channel | dir | handshake     | word
//   in_if   | in  | valid/ready   | kind, frame_bytes, trace_id, mem_read_data
//   out_if  | out | valid/ready   | out_kind, ack_frame, write_addr/len/value, gate_open, last
//   cfg_if  | in  | valid/ready   | index, data (RAM window bounds)
// A frame or gate query passes through the accept state, one state per force slot, a
// decode state, then states for write, acknowledge, reset request and final word. A step
// that emits waits while the output is blocked. Trace points and unknown kinds are
// handled in the accept state alone. One result is held back so the final word can
// carry last. Reset is synchronous; cfg_if is always ready.
`timescale 1ns / 1ps
module debug_frame_command_agent import dfca_pkg::*; (
  input logic clk,
  input logic rst_n,
  dfca_in_if.sink    in_if,
  dfca_out_if.source out_if,
  dfca_cfg_if.sink   cfg_if
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  res_t     res;
  logic     in_ready;

  dfca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_kind  (in_if.kind),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  dfca_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_kind   (in_if.kind),
    .in_frame  (in_if.frame_bytes),
    .in_tid    (in_if.trace_id),
    .in_mem    (in_if.mem_read_data),
    .cfg_wr    (cfg_if.valid),
    .cfg_idx   (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .out_res   (res)
  );

  assign in_if.ready        = in_ready;
  assign cfg_if.ready       = 1'b1;
  assign out_if.out_kind    = res.kind;
  assign out_if.ack_frame   = res.ack;
  assign out_if.write_addr  = res.addr;
  assign out_if.write_len   = res.len;
  assign out_if.write_value = res.val;
  assign out_if.gate_open   = res.gate;
  assign out_if.last        = res.last;

endmodule

// File: src/dfca_ctrl.sv
// Controller state machine: slot walk, decode and result sequencing.
`timescale 1ns / 1ps
module dfca_ctrl import dfca_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [1:0] in_kind,
  input  dp_sts_t  sts,
  output logic     in_ready,
  output ctl_cmd_t cmd
);

  localparam logic [SLOT_IDX_W-1:0] SLOT_LAST = SLOT_IDX_W'(FORCE_SLOT_COUNT - 1);

  fsm_t                  st_r, st_nxt;
  logic [SLOT_IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      idx_r <= '0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_comb begin
    st_nxt       = st_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.slot_idx = idx_r;
    in_ready     = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap = 1'b1;
          if (in_kind == IN_FRAME || in_kind == IN_GATE) begin
            st_nxt  = ST_SLOT;
            idx_nxt = '0;
          end
        end
      end
      ST_SLOT: begin
        if (!sts.slot_emit || sts.gen_ok) begin
          cmd.gen_slot = sts.slot_emit;
          if (idx_r == SLOT_LAST) st_nxt = ST_HANDLE;
          else idx_nxt = idx_r + 1'b1;
        end
      end
      ST_HANDLE: begin
        cmd.handle = 1'b1;
        st_nxt     = ST_WR;
      end
      ST_WR: begin
        if (!sts.need_w) st_nxt = ST_ACK;
        else if (sts.gen_ok) begin
          cmd.gen_w = 1'b1;
          st_nxt    = ST_ACK;
        end
      end
      ST_ACK: begin
        if (!sts.need_ack) st_nxt = ST_RST;
        else if (sts.gen_ok) begin
          cmd.gen_ack = 1'b1;
          st_nxt      = ST_RST;
        end
      end
      ST_RST: begin
        if (!sts.need_rst) st_nxt = ST_FIN;
        else if (sts.gen_ok) begin
          cmd.gen_rst = 1'b1;
          st_nxt      = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts.pend_valid) st_nxt = ST_IDLE;
        else if (sts.out_free) begin
          cmd.flush = 1'b1;
          st_nxt    = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: src/dfca_dp.sv
// Datapath: configuration, session and slot state, frame decode, result registers.
`timescale 1ns / 1ps
module dfca_dp import dfca_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_cmd_t    cmd,
  output dp_sts_t     sts,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_frame,
  input  logic [15:0] in_tid,
  input  logic [15:0] in_mem,
  input  logic        cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0] cfg_data,
  input  logic        out_ready,
  output logic        out_valid,
  output res_t        out_res
);

  logic [31:0] w0l_r, w0h_r, w1l_r, w1h_r;
  logic        online_r, paused_r, step_r, prev_valid_r;
  logic [15:0] trace_r;
  logic [63:0] prev_r;
  logic [1:0]  kind_r;
  logic [63:0] frame_r;
  logic [15:0] mem_r;
  logic [FORCE_SLOT_COUNT-1:0] act_r;
  logic [31:0] saddr_r [FORCE_SLOT_COUNT];
  logic [1:0]  ssize_r [FORCE_SLOT_COUNT];
  logic [15:0] sdata_r [FORCE_SLOT_COUNT];
  logic        need_w_r, need_a_r, need_rst_r;
  res_t        w_res_r, a_res_r;
  logic        pend_valid_r, out_valid_r;
  res_t        pend_r, out_r;

  logic [7:0]  cb, seq, b6;
  logic [31:0] faddr;
  logic [15:0] fval;
  logic        csum_ok, kx, sig_s, sig_c, is_dup, is_force;
  logic [1:0]  wr_len;
  logic [31:0] chk_addr;
  logic [1:0]  chk_len;
  logic        ram_ok;
  logic [FORCE_SLOT_COUNT-1:0] match_a;
  logic        hit_any, free_any;
  logic [SLOT_IDX_W-1:0] hit_idx, free_idx;

  logic        need_w_n, need_a_n, need_rst_n, gate_n, swr_en;
  res_kind_t   akind_n;
  logic [63:0] ack_n;
  logic        online_nxt, paused_nxt, step_nxt;
  logic [FORCE_SLOT_COUNT-1:0] act_nxt;
  logic [SLOT_IDX_W-1:0] swr_idx;
  logic [7:0]  sts_code, len8;
  logic [15:0] rd_val;

  res_t        slot_res, new_res;
  logic        gen, out_free;

  assign cb      = frame_r[7:0];
  assign seq     = frame_r[15:8];
  assign b6      = frame_r[55:48];
  assign faddr   = frame_r[47:16];
  assign fval    = frame_r[63:48];
  assign csum_ok = frame_r[63:56] == sum7(frame_r);
  assign kx      = frame_r[23:16] == CH_K && frame_r[31:24] == CH_X;
  assign sig_s   = csum_ok && kx && frame_r[39:32] == CH_M && frame_r[47:40] == CH_O
                   && b6 == CH_N;
  assign sig_c   = csum_ok && kx && frame_r[39:32] == CH_R && frame_r[47:40] == CH_T;
  assign is_dup  = prev_valid_r && prev_r == frame_r;
  assign wr_len  = (cb == CMD_WRITE8 || cb == CMD_FORCE8) ? 2'd1 : 2'd2;
  assign is_force = cb == CMD_FORCE8 || cb == CMD_FORCE16;

  assign chk_addr = cmd.handle ? faddr : saddr_r[cmd.slot_idx];
  assign chk_len  = cmd.handle ? ((cb == CMD_READ) ? b6[1:0] : wr_len) : ssize_r[cmd.slot_idx];
  assign ram_ok   = in_ram(chk_addr, chk_len, w0l_r, w0h_r, w1l_r, w1h_r);

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < FORCE_SLOT_COUNT; i++) begin
      match_a[i] = act_r[i] && saddr_r[i] == faddr;
      if (!hit_any && match_a[i] && ssize_r[i] == wr_len) begin
        hit_any = 1'b1;
        hit_idx = SLOT_IDX_W'(i);
      end
      if (!free_any && !act_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    need_w_n   = 1'b0;
    need_a_n   = 1'b0;
    need_rst_n = 1'b0;
    gate_n     = 1'b0;
    akind_n    = RES_ACK;
    ack_n      = '0;
    online_nxt = online_r;
    paused_nxt = paused_r;
    step_nxt   = step_r;
    act_nxt    = act_r;
    swr_en     = 1'b0;
    swr_idx    = free_idx;
    sts_code   = STS_OK;
    len8       = {6'b0, wr_len};
    rd_val     = '0;
    if (kind_r == IN_GATE) begin
      need_a_n = 1'b1;
      akind_n  = RES_GATE;
      gate_n   = !paused_r || step_r;
      if (paused_r && step_r) step_nxt = 1'b0;
    end else if (!is_dup) begin
      case (cb)
        CMD_OPEN, CMD_CLOSE: begin
          if (sig_s) begin
            online_nxt = cb == CMD_OPEN;
            paused_nxt = 1'b0;
            step_nxt   = 1'b0;
          end
        end
        CMD_REBOOT: begin
          if (sig_s) begin
            need_a_n   = 1'b1;
            need_rst_n = 1'b1;
            ack_n      = pack_ack(ACK_REBOOT, seq, 8'd0, 8'd0, 8'd0, 8'd0);
          end
        end
        CMD_TRACE: begin
          if (sig_s) begin
            need_a_n = 1'b1;
            ack_n    = pack_ack(ACK_TRACE, seq, trace_r[7:0], trace_r[15:8], 8'd0, 8'd0);
          end
        end
        CMD_WRITE8, CMD_WRITE16, CMD_FORCE8, CMD_FORCE16, CMD_RELEASE: begin
          need_a_n = 1'b1;
          if (!online_r) sts_code = STS_OFFLINE;
          else if (cb == CMD_RELEASE) begin
            act_nxt = act_r & ~match_a;
            len8    = 8'd0;
          end else if (!ram_ok) sts_code = STS_RANGE;
          else begin
            need_w_n = 1'b1;
            if (is_force) begin
              if (hit_any) begin
                swr_en  = 1'b1;
                swr_idx = hit_idx;
              end else if (!free_any) sts_code = STS_FULL;
              else begin
                swr_en            = 1'b1;
                act_nxt[free_idx] = 1'b1;
              end
            end
          end
          ack_n = pack_ack(ACK_WRITE, seq, sts_code, len8, cb, 8'd0);
        end
        CMD_CTRL: begin
          if (sig_c) begin
            need_a_n = 1'b1;
            case (b6)
              MODE_RUN: begin
                paused_nxt = 1'b0;
                step_nxt   = 1'b0;
              end
              MODE_PAUSE: begin
                paused_nxt = 1'b1;
                step_nxt   = 1'b0;
              end
              MODE_STEP: begin
                paused_nxt = 1'b1;
                step_nxt   = 1'b1;
              end
              default: sts_code = STS_BADLEN;
            endcase
            ack_n = pack_ack(ACK_CTRL, seq, sts_code, b6, 8'd0, 8'd0);
          end
        end
        CMD_READ: begin
          if (csum_ok) begin
            need_a_n = 1'b1;
            if (b6 != 8'd1 && b6 != 8'd2) sts_code = STS_BADLEN;
            else if (!ram_ok) sts_code = STS_RANGE;
            else rd_val = (b6 == 8'd1) ? {8'h00, mem_r[7:0]} : mem_r;
            ack_n = pack_ack(ACK_READ, seq, b6, sts_code, rd_val[7:0], rd_val[15:8]);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0l_r        <= 32'h1000_0000;
      w0h_r        <= 32'h1000_3FFF;
      w1l_r        <= 32'h2007_C000;
      w1h_r        <= 32'h2007_FFFF;
      online_r     <= 1'b0;
      paused_r     <= 1'b0;
      step_r       <= 1'b0;
      trace_r      <= '0;
      prev_valid_r <= 1'b0;
      act_r        <= '0;
      need_w_r     <= 1'b0;
      need_a_r     <= 1'b0;
      need_rst_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          CFG_W0_LO: w0l_r <= cfg_data;
          CFG_W0_HI: w0h_r <= cfg_data;
          CFG_W1_LO: w1l_r <= cfg_data;
          CFG_W1_HI: w1h_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.cap && in_kind == IN_TRACE && online_r) trace_r <= in_tid;
      if (cmd.handle) begin
        online_r   <= online_nxt;
        paused_r   <= paused_nxt;
        step_r     <= step_nxt;
        act_r      <= act_nxt;
        need_w_r   <= need_w_n;
        need_a_r   <= need_a_n;
        need_rst_r <= need_rst_n;
        if (kind_r == IN_FRAME && !is_dup) prev_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_r  <= in_kind;
      frame_r <= in_frame;
      mem_r   <= in_mem;
    end
    if (cmd.handle) begin
      if (kind_r == IN_FRAME && !is_dup) prev_r <= frame_r;
      if (swr_en) begin
        saddr_r[swr_idx] <= faddr;
        ssize_r[swr_idx] <= wr_len;
        sdata_r[swr_idx] <= fval;
      end
      w_res_r <= '{kind: RES_WRITE, ack: 64'd0, addr: faddr, len: wr_len,
                   val: (wr_len == 2'd1) ? {8'h00, fval[7:0]} : fval,
                   gate: 1'b0, last: 1'b0};
      a_res_r <= '{kind: akind_n, ack: ack_n, addr: 32'd0, len: 2'd0, val: 16'd0,
                   gate: gate_n, last: 1'b0};
    end
  end

  always_comb begin
    slot_res      = '0;
    slot_res.kind = RES_WRITE;
    slot_res.addr = saddr_r[cmd.slot_idx];
    slot_res.len  = ssize_r[cmd.slot_idx];
    slot_res.val  = (ssize_r[cmd.slot_idx] == 2'd1) ? {8'h00, sdata_r[cmd.slot_idx][7:0]}
                                                     : sdata_r[cmd.slot_idx];
    if (cmd.gen_slot) new_res = slot_res;
    else if (cmd.gen_w) new_res = w_res_r;
    else if (cmd.gen_ack) new_res = a_res_r;
    else begin
      new_res      = '0;
      new_res.kind = RES_RESET;
    end
  end

  assign gen      = cmd.gen_slot || cmd.gen_w || cmd.gen_ack || cmd.gen_rst;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (gen) begin
        if (pend_valid_r) begin
          out_r       <= pend_r;
          out_valid_r <= 1'b1;
        end else if (out_ready) out_valid_r <= 1'b0;
        pend_r       <= new_res;
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        out_r        <= '{kind: pend_r.kind, ack: pend_r.ack, addr: pend_r.addr,
                          len: pend_r.len, val: pend_r.val, gate: pend_r.gate,
                          last: 1'b1};
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.slot_emit  = act_r[cmd.slot_idx] && ram_ok;
  assign sts.gen_ok     = !pend_valid_r || out_free;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;
  assign sts.need_w     = need_w_r;
  assign sts.need_ack   = need_a_r;
  assign sts.need_rst   = need_rst_r;

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// File: src/dfca_chk.sv
// Port-level checker for the debug frame command agent, bound to the top level.
`timescale 1ns / 1ps
module dfca_chk import dfca_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [63:0] ack_frame,
  input logic [1:0]  write_len,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == RES_RESET || out_kind == RES_GATE) |-> last)
    else $error("gate answer or reset request not marked last");

  a_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == RES_WRITE |-> ack_frame == 64'd0
      && (write_len == 2'd1 || write_len == 2'd2))
    else $error("malformed memory write");

  a_csum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == RES_ACK |-> ack_frame[63:56] == sum7(ack_frame))
    else $error("acknowledge checksum wrong");

endmodule

bind debug_frame_command_agent dfca_chk u_dfca_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_kind  (out_if.out_kind),
  .ack_frame (out_if.ack_frame),
  .write_len (out_if.write_len),
  .last      (out_if.last)
);

// File: tb/testbench.sv
// Self-checking testbench for the debug frame command agent: directed and random frames.
`timescale 1ns / 1ps
module testbench import dfca_pkg::*; ();

  class frame_agent_scoreboard;
    logic [31:0] win [4];
    bit          online, paused, step_armed, prev_seen;
    logic [15:0] trace_val;
    logic [63:0] prev_frame;
    bit          slot_on [FORCE_SLOT_COUNT];
    logic [31:0] slot_addr [FORCE_SLOT_COUNT];
    logic [1:0]  slot_len [FORCE_SLOT_COUNT];
    logic [15:0] slot_val [FORCE_SLOT_COUNT];
    res_t        expected_words [$];
    int          mismatches, words_checked, items_noted;

    function void clear();
      win[0] = 32'h1000_0000; win[1] = 32'h1000_3FFF;
      win[2] = 32'h2007_C000; win[3] = 32'h2007_FFFF;
      online = 0; paused = 0; step_armed = 0; prev_seen = 0;
      trace_val = '0; prev_frame = '0;
      foreach (slot_on[i]) slot_on[i] = 0;
    endfunction

    function bit fits(logic [31:0] a, logic [7:0] n);
      logic [32:0] tail;
      tail = {1'b0, a} + 33'(n) - 33'd1;
      if (tail > 33'h0_FFFF_FFFF) return 0;
      return (a >= win[0] && tail[31:0] <= win[1]) || (a >= win[2] && tail[31:0] <= win[3]);
    endfunction

    function logic [63:0] ack_word(logic [7:0] b0, b1, b2, b3, b4, b5);
      logic [7:0] s;
      s = b0 + b1 + b2 + b3 + b4 + b5;
      return {s, 8'h00, b5, b4, b3, b2, b1, b0};
    endfunction

    function void add(res_kind_t k, logic [63:0] a, logic [31:0] ad, logic [1:0] n,
                      logic [15:0] v, logic g);
      res_t r;
      r = '{kind: k, ack: a, addr: ad, len: n, val: v, gate: g, last: 1'b0};
      expected_words.push_back(r);
    endfunction

    function void add_write(logic [31:0] ad, logic [1:0] n, logic [15:0] v);
      add(RES_WRITE, '0, ad, n, (n == 2'd1) ? {8'h00, v[7:0]} : v, 1'b0);
    endfunction

    function void add_ack(logic [7:0] b0, b1, b2, b3, b4, b5);
      add(RES_ACK, ack_word(b0, b1, b2, b3, b4, b5), '0, '0, '0, 1'b0);
    endfunction

    function bit signed_ok(logic [63:0] f, bit session);
      logic [7:0] s;
      s = 8'h00;
      for (int i = 0; i < 7; i++) s = s + f[8*i +: 8];
      if (f[63:56] != s || f[23:16] != CH_K || f[31:24] != CH_X) return 0;
      if (session) return f[39:32] == CH_M && f[47:40] == CH_O && f[55:48] == CH_N;
      return f[39:32] == CH_R && f[47:40] == CH_T;
    endfunction

    function void decode(logic [63:0] f, logic [15:0] mem);
      logic [7:0]  cmd, seq, status, n, csum;
      logic [31:0] ad;
      logic [15:0] v;
      int          hit, free_idx;
      cmd = f[7:0]; seq = f[15:8]; ad = f[47:16]; v = f[63:48]; status = STS_OK;
      csum = 8'h00;
      for (int i = 0; i < 7; i++) csum = csum + f[8*i +: 8];
      case (cmd)
        CMD_OPEN, CMD_CLOSE: if (signed_ok(f, 1)) begin
          online = (cmd == CMD_OPEN); paused = 0; step_armed = 0;
        end
        CMD_REBOOT: if (signed_ok(f, 1)) begin
          add_ack(ACK_REBOOT, seq, 0, 0, 0, 0);
          add(RES_RESET, '0, '0, '0, '0, 1'b0);
        end
        CMD_TRACE: if (signed_ok(f, 1)) add_ack(ACK_TRACE, seq, trace_val[7:0], trace_val[15:8], 0, 0);
        CMD_WRITE8, CMD_WRITE16, CMD_FORCE8, CMD_FORCE16, CMD_RELEASE: begin
          n = (cmd == CMD_WRITE8 || cmd == CMD_FORCE8) ? 8'd1 : 8'd2;
          if (!online) begin
            status = STS_OFFLINE;
          end else if (cmd == CMD_RELEASE) begin
            foreach (slot_on[i]) if (slot_on[i] && slot_addr[i] == ad) slot_on[i] = 0;
            n = 8'd0;
          end else if (!fits(ad, n)) begin
            status = STS_RANGE;
          end else begin
            add_write(ad, n[1:0], v);
            if (cmd == CMD_FORCE8 || cmd == CMD_FORCE16) begin
              hit = -1; free_idx = -1;
              for (int i = 0; i < FORCE_SLOT_COUNT; i++) begin
                if (slot_on[i] && slot_addr[i] == ad && slot_len[i] == n[1:0]) begin
                  hit = i;
                  break;
                end
                if (free_idx < 0 && !slot_on[i]) free_idx = i;
              end
              if (hit >= 0) begin
                slot_val[hit] = v;
              end else if (free_idx < 0) begin
                status = STS_FULL;
              end else begin
                slot_on[free_idx] = 1; slot_addr[free_idx] = ad;
                slot_len[free_idx] = n[1:0]; slot_val[free_idx] = v;
              end
            end
          end
          add_ack(ACK_WRITE, seq, status, n, cmd, 0);
        end
        CMD_CTRL: if (signed_ok(f, 0)) begin
          case (f[55:48])
            MODE_RUN: begin paused = 0; step_armed = 0; end
            MODE_PAUSE: begin paused = 1; step_armed = 0; end
            MODE_STEP: begin paused = 1; step_armed = 1; end
            default: status = STS_BADLEN;
          endcase
          add_ack(ACK_CTRL, seq, status, f[55:48], 0, 0);
        end
        CMD_READ: if (f[63:56] == csum) begin
          n = f[55:48]; v = '0;
          if (n != 8'd1 && n != 8'd2) status = STS_BADLEN;
          else if (!fits(ad, n)) status = STS_RANGE;
          else v = (n == 8'd1) ? {8'h00, mem[7:0]} : mem;
          add_ack(ACK_READ, seq, n, status, v[7:0], v[15:8]);
        end
        default: ;
      endcase
    endfunction

    function void note_input(in_kind_t k, logic [63:0] f, logic [15:0] tid, logic [15:0] mem);
      int   start;
      logic open;
      res_t r;
      items_noted++;
      start = expected_words.size();
      if (k == IN_TRACE) begin
        if (online) trace_val = tid;
        return;
      end
      if (k == IN_NONE) return;
      for (int i = 0; i < FORCE_SLOT_COUNT; i++)
        if (slot_on[i] && (slot_len[i] == 2'd1 || slot_len[i] == 2'd2) &&
            fits(slot_addr[i], 8'(slot_len[i])))
          add_write(slot_addr[i], slot_len[i], slot_val[i]);
      if (k == IN_GATE) begin
        open = 0;
        if (!paused) open = 1;
        else if (step_armed) begin step_armed = 0; open = 1; end
        add(RES_GATE, '0, '0, '0, '0, open);
      end else if (!(prev_seen && prev_frame == f)) begin
        prev_seen = 1; prev_frame = f;
        decode(f, mem);
      end
      if (expected_words.size() > start) begin
        r = expected_words.pop_back();
        r.last = 1'b1;
        expected_words.push_back(r);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
        return;
      end
      want = expected_words.pop_front();
      if (got.kind != want.kind || got.ack != want.ack || got.addr != want.addr ||
          got.len != want.len || got.val != want.val || got.gate != want.gate ||
          got.last != want.last) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  dfca_in_if  in_ch ();
  dfca_out_if out_ch ();
  dfca_cfg_if cfg_ch ();

  debug_frame_command_agent dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source), .cfg_if(cfg_ch.sink)
  );

  frame_agent_scoreboard sb = new();
  bit          calm, squeeze_req;
  bit          squeeze_done = 1'b0;
  int          hold_left = 0;
  logic [63:0] last_frame;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    res_t got;
    if (out_ch.valid && out_ch.ready) begin
      got.kind = res_kind_t'(out_ch.out_kind); got.ack = out_ch.ack_frame;
      got.addr = out_ch.write_addr; got.len = out_ch.write_len;
      got.val = out_ch.write_value; got.gate = out_ch.gate_open; got.last = out_ch.last;
      sb.check_result(got);
    end
    if (squeeze_req && !squeeze_done && hold_left == 0) begin
      hold_left <= 400;
      squeeze_done <= 1'b1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  function automatic logic [63:0] framed(logic [7:0] b0, b1, b2, b3, b4, b5, b6);
    logic [7:0] s;
    s = b0 + b1 + b2 + b3 + b4 + b5 + b6;
    return {s, b6, b5, b4, b3, b2, b1, b0};
  endfunction

  function automatic logic [63:0] session_frame(logic [7:0] cmd);
    return framed(cmd, 8'($urandom), CH_K, CH_X, CH_M, CH_O, CH_N);
  endfunction

  function automatic logic [63:0] ctrl_frame(logic [7:0] mode);
    return framed(CMD_CTRL, 8'($urandom), CH_K, CH_X, CH_R, CH_T, mode);
  endfunction

  function automatic logic [63:0] read_frame(logic [31:0] a, logic [7:0] n);
    return framed(CMD_READ, 8'($urandom), a[7:0], a[15:8], a[23:16], a[31:24], n);
  endfunction

  function automatic logic [63:0] write_frame(logic [7:0] cmd, logic [31:0] a, logic [15:0] v);
    return {v, a, 8'($urandom), cmd};
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(7))
      0: return sb.win[0] + $urandom_range(3);
      1: return sb.win[1] - $urandom_range(2);
      2: return sb.win[2] + $urandom_range(40);
      3: return sb.win[3] - $urandom_range(2);
      4: return 32'hFFFF_FFFF - $urandom_range(1);
      5: return sb.win[0] - 1;
      6: return $urandom;
      default: return sb.win[0] + $urandom_range(64);
    endcase
  endfunction

  task automatic send_item(in_kind_t k, logic [63:0] f);
    while (!calm && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.frame_bytes <= f;
    in_ch.trace_id <= 16'($urandom);
    in_ch.mem_read_data <= 16'($urandom);
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(k, in_ch.frame_bytes, in_ch.trace_id, in_ch.mem_read_data);
    if (k == IN_FRAME) last_frame = f;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_windows(logic [31:0] w0l, w0h, w1l, w1h);
    logic [31:0] vals [4];
    vals = '{w0l, w0h, w1l, w1h};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= 8'(i);
      cfg_ch.data <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      sb.win[i] = vals[i];
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_item();
    logic [63:0] f;
    logic [7:0]  cmds [8];
    int          r;
    cmds = '{CMD_WRITE8, CMD_WRITE16, CMD_FORCE8, CMD_FORCE16, CMD_RELEASE, CMD_READ,
             CMD_CTRL, CMD_TRACE};
    r = $urandom_range(99);
    if (r < 10) begin
      send_item(IN_GATE, 64'($urandom) << 32 | 64'($urandom));
    end else if (r < 16) begin
      send_item(IN_TRACE, '0);
    end else if (r < 18) begin
      send_item(IN_NONE, '0);
    end else if (r < 22) begin
      send_item(IN_FRAME, last_frame);
    end else if (r < 28) begin
      send_item(IN_FRAME, {32'($urandom), 32'($urandom)});
    end else begin
      case ($urandom_range(11))
        0: f = session_frame(CMD_OPEN);
        1: f = session_frame(($urandom_range(3) == 0) ? CMD_CLOSE : CMD_OPEN);
        2: f = session_frame(($urandom_range(4) == 0) ? CMD_REBOOT : CMD_TRACE);
        3: f = ctrl_frame(($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(2)));
        4, 5: f = read_frame(pick_addr(),
                             ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2)));
        default: f = write_frame(cmds[$urandom_range(4)], pick_addr(), 16'($urandom));
      endcase
      if ($urandom_range(9) == 0) f[$urandom_range(63)] ^= 1'b1;
      send_item(IN_FRAME, f);
    end
  endtask

  initial begin
    sb.clear();
    rst_n = 1'b0; calm = 1'b0; squeeze_req = 1'b0; last_frame = '0;
    in_ch.valid = 1'b0; in_ch.kind = '0; in_ch.frame_bytes = '0;
    in_ch.trace_id = '0; in_ch.mem_read_data = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_windows(32'h1000_0000, 32'h1000_3FFF, 32'h2007_C000, 32'h2007_FFFF);

    send_item(IN_FRAME, write_frame(CMD_WRITE16, 32'h1000_0000, 16'hFFFF));
    send_item(IN_FRAME, session_frame(CMD_OPEN));
    send_item(IN_FRAME, session_frame(CMD_OPEN));
    send_item(IN_FRAME, write_frame(CMD_WRITE8, 32'h1000_0000, 16'hFFFF));
    send_item(IN_FRAME, write_frame(CMD_WRITE16, 32'h1000_3FFF, 16'h1234));
    send_item(IN_FRAME, write_frame(CMD_WRITE16, 32'hFFFF_FFFF, 16'h0000));
    send_item(IN_FRAME, read_frame(32'h2007_FFFE, 8'd2));
    send_item(IN_FRAME, read_frame(32'h2007_FFFF, 8'd1));
    send_item(IN_FRAME, read_frame(32'h1000_0000, 8'd0));
    send_item(IN_FRAME, read_frame(32'h0000_0000, 8'd1));
    for (int i = 0; i < 9; i++)
      send_item(IN_FRAME, write_frame((i % 2) ? CMD_FORCE16 : CMD_FORCE8,
                                      32'h1000_0010 + 4 * i, 16'hA55A ^ 16'(i)));
    send_item(IN_FRAME, write_frame(CMD_RELEASE, 32'h1000_0010, 16'h0000));
    send_item(IN_FRAME, ctrl_frame(MODE_PAUSE));
    send_item(IN_GATE, '0);
    send_item(IN_FRAME, ctrl_frame(MODE_STEP));
    send_item(IN_GATE, '0);
    send_item(IN_GATE, '0);
    send_item(IN_FRAME, ctrl_frame(8'hFF));
    send_item(IN_TRACE, '0);
    send_item(IN_FRAME, session_frame(CMD_TRACE));
    send_item(IN_FRAME, session_frame(CMD_REBOOT));
    send_item(IN_NONE, '1);
    send_item(IN_FRAME, session_frame(CMD_CLOSE));
    send_item(IN_FRAME, write_frame(CMD_FORCE8, 32'h1000_0000, 16'h0001));
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_windows(32'h1000_0000, 32'h1000_3FFF, 32'h2007_C000, 32'h2007_FFFF);
        1: write_windows(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        2: write_windows(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        default: write_windows($urandom, $urandom, 32'h1000_0020, 32'h1000_00FF);
      endcase
      for (int i = 0; i < 37; i++) begin
        if (ph == 1 && i == 5) squeeze_req = 1'b1;
        calm = (ph == 2 && i >= 5 && i < 30);
        random_item();
      end
      calm = 1'b0;
      settle();
    end

    $display("covered %0d items, %0d result words, four window settings",
             sb.items_noted, sb.words_checked);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: sim.f
src/dfca_pkg.sv
src/dfca_ifs.sv
src/dfca_ctrl.sv
src/dfca_dp.sv
src/debug_frame_command_agent.sv
src/dfca_chk.sv
tb/testbench.sv
